/* design/crmc_pkg.sv */
`timescale 1ns / 1ps

package crmc_pkg;

   // Table geometry.
   localparam int ENTRY_COUNT     = 256;
   localparam int ENTRY_BITS      = $clog2(ENTRY_COUNT);
   localparam int MAP_NUMBER_BITS = 24;

   // Widths of the transaction fields on the ports.
   localparam int OPCODE_W     = 2;
   localparam int INDEX_W      = 8;
   localparam int NUMBER_W     = 24;

   typedef enum logic [OPCODE_W-1:0] {
      OP_EVICT        = 2'd0,
      OP_TOUCH        = 2'd1,
      OP_FILL_PAGE    = 2'd2,
      OP_FILL_EXTENTS = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_SWEEP,
      ST_REPORT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;   // zero the flags of the entry under the clear counter
      logic latch_req;    // capture the request fields
      logic do_update;    // apply a touch or fill to the addressed entry
      logic sweep_clear;  // clear the reference bit under the hand and advance
      logic sweep_take;   // take the entry under the hand as the victim
   } ctl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;       // the clearing pass is at the last entry
      logic hand_referenced;  // reference bit of the entry under the hand
   } ctl_status_type;

endpackage

/* design/crmc_ctrl.sv */
`timescale 1ns / 1ps

module crmc_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [crmc_pkg::OPCODE_W-1:0] req_opcode,
   input  crmc_pkg::ctl_status_type     status,
   output crmc_pkg::ctl_cmd_type        cmd,
   output logic                         busy,
   output logic                         rsp_valid
);
   import crmc_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = (req_opcode == OP_EVICT) ? ST_SWEEP : ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            if (!status.hand_referenced) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            busy          = 1'b0;
            cmd.latch_req = start;
         end
         ST_UPDATE: begin
            cmd.do_update = 1'b1;
         end
         ST_SWEEP: begin
            cmd.sweep_clear = status.hand_referenced;
            cmd.sweep_take  = !status.hand_referenced;
         end
         ST_REPORT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // A result appears only right after the sweep has taken a victim.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.sweep_take))
      else $error("result strobe without a preceding victim pick");

   // An accepted touch or fill is applied in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode != OP_EVICT) |=> cmd.do_update)
      else $error("touch or fill not applied after acceptance");

   // The block is free again right after a result has been shown.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after reporting a victim");

endmodule

/* design/crmc_datapath.sv */
`timescale 1ns / 1ps

module crmc_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  crmc_pkg::ctl_cmd_type          cmd,
   output crmc_pkg::ctl_status_type       status,
   input  logic [crmc_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [crmc_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [crmc_pkg::NUMBER_W-1:0]  req_map_number,
   input  logic                           req_write_hit,
   output logic [crmc_pkg::INDEX_W-1:0]   rsp_victim_index,
   output logic                           rsp_victim_dirty,
   output logic                           rsp_victim_is_page_map,
   output logic [crmc_pkg::NUMBER_W-1:0]  rsp_victim_map_number
);
   import crmc_pkg::*;

   // Captured request.
   logic [OPCODE_W-1:0]        opcode_ff;
   logic [INDEX_W-1:0]         index_ff;
   logic [MAP_NUMBER_BITS-1:0] number_ff;
   logic                       write_ff;

   // Per-entry flags and map numbers live in RAMs with one write port each. The flags
   // are zeroed by the clearing pass after reset; the map numbers are left alone.
   logic                       ref_mem   [ENTRY_COUNT];
   logic                       dirty_mem [ENTRY_COUNT];
   logic                       kind_mem  [ENTRY_COUNT];
   logic [MAP_NUMBER_BITS-1:0] map_mem   [ENTRY_COUNT];

   logic [ENTRY_BITS-1:0]  hand_ff,  hand_in;
   logic [ENTRY_BITS-1:0]  clear_ff, clear_in;
   logic                   ref_rd_ff;

   // Victim result registers.
   logic [INDEX_W-1:0]         victim_index_ff;
   logic                       victim_dirty_ff;
   logic                       victim_kind_ff;
   logic [MAP_NUMBER_BITS-1:0] victim_number_ff;

   logic [ENTRY_BITS-1:0] slot;
   logic                  in_range;
   logic                  is_fill;
   logic                  update_en;
   logic [ENTRY_BITS-1:0] hand_next;

   // Write ports of the flag RAMs.
   logic                  ref_we;
   logic [ENTRY_BITS-1:0] ref_addr;
   logic                  ref_wdata;
   logic                  dirty_we;
   logic [ENTRY_BITS-1:0] dirty_addr;
   logic                  dirty_wdata;
   logic                  kind_we;
   logic [ENTRY_BITS-1:0] kind_addr;
   logic                  kind_wdata;

   assign slot      = ENTRY_BITS'(index_ff);
   assign in_range  = 32'(index_ff) < ENTRY_COUNT;
   assign is_fill   = (opcode_ff == OP_FILL_PAGE) || (opcode_ff == OP_FILL_EXTENTS);
   assign update_en = cmd.do_update && in_range;
   assign hand_next = (hand_ff == ENTRY_BITS'(ENTRY_COUNT - 1)) ? '0 : hand_ff + 1'b1;

   // The reference bit under the hand is read ahead: the read address is the
   // next hand position. Nothing is written in the cycle that accepts an evict, and a
   // sweep step writes only the entry it leaves, so the data is current while sweeping.
   assign status.hand_referenced = ref_rd_ff;
   assign status.clear_last      = (clear_ff == ENTRY_BITS'(ENTRY_COUNT - 1));

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         opcode_ff <= req_opcode;
         index_ff  <= req_entry_index;
         number_ff <= MAP_NUMBER_BITS'(req_map_number);
         write_ff  <= req_write_hit;
      end
   end

   always_comb begin
      hand_in  = hand_ff;
      clear_in = clear_ff;
      if (cmd.sweep_clear || cmd.sweep_take) begin
         hand_in = hand_next;
      end
      if (cmd.clear_step) begin
         clear_in = clear_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hand_ff  <= '0;
         clear_ff <= '0;
      end else begin
         hand_ff  <= hand_in;
         clear_ff <= clear_in;
      end
   end

   // At most one source writes each flag RAM in a cycle.
   always_comb begin
      ref_we      = 1'b0;
      ref_addr    = hand_ff;
      ref_wdata   = 1'b0;
      dirty_we    = 1'b0;
      dirty_addr  = hand_ff;
      dirty_wdata = 1'b0;
      kind_we     = 1'b0;
      kind_addr   = slot;
      kind_wdata  = 1'b0;
      if (cmd.clear_step) begin
         ref_we     = 1'b1;
         ref_addr   = clear_ff;
         dirty_we   = 1'b1;
         dirty_addr = clear_ff;
         kind_we    = 1'b1;
         kind_addr  = clear_ff;
      end
      if (update_en) begin
         ref_we      = 1'b1;
         ref_addr    = slot;
         ref_wdata   = 1'b1;
         dirty_we    = write_ff;
         dirty_addr  = slot;
         dirty_wdata = 1'b1;
         kind_we     = is_fill;
         kind_addr   = slot;
         kind_wdata  = (opcode_ff == OP_FILL_PAGE);
      end
      if (cmd.sweep_clear) begin
         ref_we    = 1'b1;
         ref_addr  = hand_ff;
         ref_wdata = 1'b0;
      end
      if (cmd.sweep_take) begin
         ref_we      = 1'b1;
         ref_addr    = hand_ff;
         ref_wdata   = 1'b1;
         dirty_we    = 1'b1;
         dirty_addr  = hand_ff;
         dirty_wdata = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ref_we) begin
         ref_mem[ref_addr] <= ref_wdata;
      end
      ref_rd_ff <= ref_mem[hand_in];
   end

   always_ff @(posedge clock) begin
      if (dirty_we) begin
         dirty_mem[dirty_addr] <= dirty_wdata;
      end
      if (cmd.sweep_take) begin
         victim_dirty_ff <= dirty_mem[hand_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (kind_we) begin
         kind_mem[kind_addr] <= kind_wdata;
      end
      if (cmd.sweep_take) begin
         victim_kind_ff <= kind_mem[hand_ff];
      end
   end

   // Map number RAM: written by fills, read once when a victim is taken.
   always_ff @(posedge clock) begin
      if (update_en && is_fill) begin
         map_mem[slot] <= number_ff;
      end
      if (cmd.sweep_take) begin
         victim_number_ff <= map_mem[hand_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_take) begin
         victim_index_ff <= INDEX_W'(hand_ff);
      end
   end

   assign rsp_victim_index       = victim_index_ff;
   assign rsp_victim_dirty       = victim_dirty_ff;
   assign rsp_victim_is_page_map = victim_kind_ff;
   assign rsp_victim_map_number  = NUMBER_W'(victim_number_ff);

   // The victim is left referenced and clean.
   assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_take |=> (ref_mem[$past(hand_ff)] && !dirty_mem[$past(hand_ff)]))
      else $error("victim entry not marked referenced and clean");

   // Every sweep step moves the hand.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.sweep_clear || cmd.sweep_take) |=> hand_ff != $past(hand_ff))
      else $error("clock hand did not advance");

   // A victim is only ever taken at an entry whose reference bit is clear.
   assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_take |-> !status.hand_referenced)
      else $error("victim taken at a referenced entry");

endmodule

/* design/clock_replacement_map_cache_index.sv */
`timescale 1ns / 1ps
// Touch and fill: applied in the cycle after acceptance, with busy high while applied.
// Evict: the hand visits one entry per cycle and passes over at most 256 referenced
// entries; the victim strobe follows the pick, and the next transaction can follow
// the strobe. Results are shown for exactly one cycle. Synchronous active-high reset
// zeroes the hand; a clearing pass over all 256 entries with busy high then zeroes
// all reference, dirty and kind flags. The receiver cannot stall.

module clock_replacement_map_cache_index (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [crmc_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [crmc_pkg::INDEX_W-1:0]   req_entry_index,
   input  logic [crmc_pkg::NUMBER_W-1:0]  req_map_number,
   input  logic                           req_write_hit,
   output logic                           rsp_valid,
   output logic [crmc_pkg::INDEX_W-1:0]   rsp_victim_index,
   output logic                           rsp_victim_dirty,
   output logic                           rsp_victim_is_page_map,
   output logic [crmc_pkg::NUMBER_W-1:0]  rsp_victim_map_number
);
   import crmc_pkg::*;

   // The controller sequences each transaction and the clearing pass; the datapath
   // holds the per-entry flag RAMs, the map number RAM, the clock hand and the result.
   ctl_cmd_type    cmd;
   ctl_status_type status;

   crmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   crmc_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_opcode             (req_opcode),
      .req_entry_index        (req_entry_index),
      .req_map_number         (req_map_number),
      .req_write_hit          (req_write_hit),
      .rsp_victim_index       (rsp_victim_index),
      .rsp_victim_dirty       (rsp_victim_dirty),
      .rsp_victim_is_page_map (rsp_victim_is_page_map),
      .rsp_victim_map_number  (rsp_victim_map_number)
   );

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the clock-replacement index table of the mapping-page cache.
//
// The stimulus is queued up front by an initial block. A driver clocked on the falling
// edge hands one transaction at a time to the block and holds it until start meets a
// low busy. A monitor clocked on the rising edge sees the same handshake. For every
// accepted transaction it advances a private copy of the table (reference, dirty and
// kind flags, map numbers and the clock hand) and queues the victim that an evict must
// report. Each rsp_valid strobe is then checked field by field against the oldest
// queued victim.

module tb_top;
   import crmc_pkg::*;

   // One queued transaction for the driver. A set hold_for_drain makes the driver pause
   // in front of it until every outstanding victim has been reported.
   typedef struct {
      opcode_type           op;
      logic [INDEX_W-1:0]   entry;
      logic [NUMBER_W-1:0]  number;
      logic                 write_hit;
      bit                   hold_for_drain;
   } cache_cmd_type;

   // One victim that an evict is expected to report.
   typedef struct {
      logic [INDEX_W-1:0]   entry;
      logic                 dirty;
      logic                 is_page_map;
      logic [NUMBER_W-1:0]  number;
   } victim_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [OPCODE_W-1:0]   req_opcode = OP_TOUCH;
   logic [INDEX_W-1:0]    req_entry_index = '0;
   logic [NUMBER_W-1:0]   req_map_number = '0;
   logic                  req_write_hit = 1'b0;
   logic                  rsp_valid;
   logic [INDEX_W-1:0]    rsp_victim_index;
   logic                  rsp_victim_dirty;
   logic                  rsp_victim_is_page_map;
   logic [NUMBER_W-1:0]   rsp_victim_map_number;

   clock_replacement_map_cache_index uut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_opcode             (req_opcode),
      .req_entry_index        (req_entry_index),
      .req_map_number         (req_map_number),
      .req_write_hit          (req_write_hit),
      .rsp_valid              (rsp_valid),
      .rsp_victim_index       (rsp_victim_index),
      .rsp_victim_dirty       (rsp_victim_dirty),
      .rsp_victim_is_page_map (rsp_victim_is_page_map),
      .rsp_victim_map_number  (rsp_victim_map_number)
   );

   always #4 clock = ~clock;

   // Reset is held high from time zero and released on a falling edge, like every input.
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Shadow copy of the table. Nothing here is ever reset again after time zero.
   // ---------------------------------------------------------------------------------
   bit                  ref_bit   [ENTRY_COUNT];
   bit                  dirty_bit [ENTRY_COUNT];
   bit                  page_bit  [ENTRY_COUNT];
   logic [NUMBER_W-1:0] map_no    [ENTRY_COUNT];
   int unsigned         sweep_hand = 0;

   cache_cmd_type cmd_queue[$];
   victim_type    victim_queue[$];

   // Shared between the monitor (writer, rising edge) and the driver (reader, falling
   // edge): whether the transaction on the ports was taken at the last rising edge.
   bit req_taken = 1'b0;
   int gap_left = 0;

   int failures = 0;
   int accepted = 0;
   int victims_checked = 0;
   int dirty_victims = 0;
   int full_laps = 0;

   // Advances the shadow table by one accepted transaction. An evict walks the hand,
   // clearing every set reference bit it passes, and queues the first clear entry as
   // the victim. When every entry was referenced the hand clears a whole lap and comes
   // back to where it started.
   function automatic void table_apply(opcode_type op, logic [INDEX_W-1:0] entry,
                                       logic [NUMBER_W-1:0] number, logic write_hit);
      int unsigned here;
      int unsigned skipped;
      victim_type  v;
      if (op == OP_EVICT) begin
         here = sweep_hand;
         skipped = 0;
         while (ref_bit[here]) begin
            ref_bit[here] = 1'b0;
            here = (here + 1) % ENTRY_COUNT;
            skipped++;
         end
         if (skipped == ENTRY_COUNT)
            full_laps++;
         sweep_hand = (here + 1) % ENTRY_COUNT;
         ref_bit[here] = 1'b1;
         v.entry       = here[INDEX_W-1:0];
         v.dirty       = dirty_bit[here];
         v.is_page_map = page_bit[here];
         v.number      = map_no[here];
         dirty_bit[here] = 1'b0;
         victim_queue.push_back(v);
      end else if (entry < ENTRY_COUNT) begin
         // An index beyond the table would be dropped; with 256 entries none exists.
         if (op == OP_FILL_PAGE || op == OP_FILL_EXTENTS) begin
            map_no[entry]   = number;
            page_bit[entry] = (op == OP_FILL_PAGE);
         end
         ref_bit[entry] = 1'b1;
         if (write_hit)
            dirty_bit[entry] = 1'b1;
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Monitor: checks each strobed victim, then records the transaction taken this edge.
   // A victim is reported only after its evict has passed through the sweep state, so
   // the order of the two steps within one edge does not matter.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      victim_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (victim_queue.size() == 0) begin
            $error("unexpected victim report: entry %0d", rsp_victim_index);
            failures++;
         end else begin
            want = victim_queue.pop_front();
            victims_checked++;
            if (want.dirty)
               dirty_victims++;
            if (rsp_victim_index !== want.entry) begin
               $error("victim_index: expected %0d, actual %0d", want.entry,
                      rsp_victim_index);
               failures++;
            end
            if (rsp_victim_dirty !== want.dirty) begin
               $error("victim_dirty: expected %0b, actual %0b", want.dirty,
                      rsp_victim_dirty);
               failures++;
            end
            if (rsp_victim_is_page_map !== want.is_page_map) begin
               $error("victim_is_page_map: expected %0b, actual %0b", want.is_page_map,
                      rsp_victim_is_page_map);
               failures++;
            end
            if (rsp_victim_map_number !== want.number) begin
               $error("victim_map_number: expected 0x%06h, actual 0x%06h", want.number,
                      rsp_victim_map_number);
               failures++;
            end
         end
      end else if (!reset && rsp_valid !== 1'b0) begin
         $error("rsp_valid: expected 0 or 1, actual %b", rsp_valid);
         failures++;
      end

      req_taken = !reset && start && !busy;
      if (req_taken) begin
         table_apply(opcode_type'(req_opcode), req_entry_index, req_map_number,
                     req_write_hit);
         accepted++;
      end
   end

   // ---------------------------------------------------------------------------------
   // Driver: on each falling edge it either holds a transaction that has not been taken
   // yet or chooses what to show next. Idle bursts are scattered over the run, with
   // quiet stretches between them and none in the last part. While start is low the
   // request ports carry random junk that the block must ignore.
   // ---------------------------------------------------------------------------------
   always @(negedge clock) begin
      cache_cmd_type c;
      bit            drive;
      drive = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (cmd_queue.size() > 0 &&
                      !(cmd_queue[0].hold_for_drain && victim_queue.size() > 0)) begin
            c = cmd_queue.pop_front();
            drive = 1'b1;
            // Gaps only outside every third stretch of 64 items and not near the end.
            if (cmd_queue.size() > 150 && (cmd_queue.size() / 64) % 3 != 0 &&
                $urandom_range(0, 3) == 0)
               gap_left = $urandom_range(1, 6);
         end
         if (drive) begin
            req_opcode      <= c.op;
            req_entry_index <= c.entry;
            req_map_number  <= c.number;
            req_write_hit   <= c.write_hit;
         end else begin
            req_opcode      <= OPCODE_W'($urandom_range(0, 3));
            req_entry_index <= INDEX_W'($urandom_range(0, 255));
            req_map_number  <= NUMBER_W'($urandom);
            req_write_hit   <= 1'($urandom_range(0, 1));
         end
         start <= drive;
      end
   end

   task automatic push_cmd(opcode_type op, int entry, logic [NUMBER_W-1:0] number,
                           logic write_hit, bit hold_for_drain = 1'b0);
      cache_cmd_type c;
      c.op             = op;
      c.entry          = entry[INDEX_W-1:0];
      c.number         = number;
      c.write_hit      = write_hit;
      c.hold_for_drain = hold_for_drain;
      cmd_queue.push_back(c);
   endtask

   function automatic opcode_type any_fill();
      return ($urandom_range(0, 1) != 0) ? OP_FILL_PAGE : OP_FILL_EXTENTS;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus and end of run.
   // ---------------------------------------------------------------------------------
   initial begin
      int order[ENTRY_COUNT];
      int j;
      int swap;
      int pick;
      int hot_base;
      int n;
      int victim_hint;

      // Bring-up: fill every entry once, in shuffled order, so that no evict can land
      // on an entry whose map number was never written.
      for (int i = 0; i < ENTRY_COUNT; i++)
         order[i] = i;
      for (int i = ENTRY_COUNT - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      foreach (order[i])
         push_cmd(any_fill(), order[i], NUMBER_W'($urandom), 1'($urandom_range(0, 1)));

      // Directed part. The table is now fully referenced, so the first evict clears a
      // whole lap and takes the entry where the hand started; the driver also waits
      // here for the table to go quiet.
      push_cmd(OP_EVICT, 0, '0, 1'b0, 1'b1);
      push_cmd(OP_FILL_PAGE, 255, 24'hFFFFFF, 1'b1);
      push_cmd(OP_FILL_EXTENTS, 0, 24'h000000, 1'b0);
      push_cmd(OP_TOUCH, 128, 24'hFFFFFF, 1'b1);
      push_cmd(OP_TOUCH, 129, 24'h000000, 1'b0);
      push_cmd(OP_FILL_PAGE, 3, 24'h000000, 1'b1);
      push_cmd(OP_FILL_EXTENTS, 2, 24'hFFFFFF, 1'b1);
      push_cmd(OP_FILL_PAGE, 5, 24'h800001, 1'b0);
      push_cmd(OP_TOUCH, 4, 24'h7FFFFE, 1'b1);
      repeat (6)
         push_cmd(OP_EVICT, 255, 24'hFFFFFF, 1'b1);
      push_cmd(OP_TOUCH, 255, 24'h000000, 1'b0);
      push_cmd(OP_TOUCH, 0, 24'h000000, 1'b1);
      push_cmd(OP_FILL_EXTENTS, 254, 24'hFFFFFF, 1'b0);
      repeat (4)
         push_cmd(OP_EVICT, 0, '0, 1'b0);

      // Random part. Touches cluster on a wandering hot set so that some entries stay
      // referenced and sweeps grow long; miss sequences evict, refill and then touch a
      // line the way a cache controller would.
      hot_base = $urandom_range(0, ENTRY_COUNT - 16);
      n = 0;
      while (n < 750) begin
         if (n >= 375 && n < 380) begin
            // Touch every entry, then evict: another full-lap sweep, issued from a
            // quiet table.
            for (int i = ENTRY_COUNT - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               swap = order[i];
               order[i] = order[j];
               order[j] = swap;
            end
            foreach (order[i])
               push_cmd(OP_TOUCH, order[i], NUMBER_W'($urandom),
                        1'($urandom_range(0, 1)), i == 0);
            push_cmd(OP_EVICT, 0, NUMBER_W'($urandom), 1'($urandom_range(0, 1)));
            n = 380;
         end
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 31) == 0)
            hot_base = $urandom_range(0, ENTRY_COUNT - 16);
         if (pick < 40) begin
            push_cmd(OP_TOUCH, (pick < 22) ? hot_base + $urandom_range(0, 15)
                                           : $urandom_range(0, 255),
                     NUMBER_W'($urandom), 1'($urandom_range(0, 1)));
            n++;
         end else if (pick < 62) begin
            push_cmd(any_fill(), $urandom_range(0, 255), NUMBER_W'($urandom),
                     1'($urandom_range(0, 1)));
            n++;
         end else if (pick < 88) begin
            push_cmd(OP_EVICT, $urandom_range(0, 255), NUMBER_W'($urandom),
                     1'($urandom_range(0, 1)));
            n++;
         end else begin
            victim_hint = $urandom_range(0, 255);
            push_cmd(OP_EVICT, $urandom_range(0, 255), NUMBER_W'($urandom),
                     1'($urandom_range(0, 1)));
            push_cmd(any_fill(), victim_hint, NUMBER_W'($urandom), 1'b0);
            push_cmd(OP_TOUCH, victim_hint, NUMBER_W'($urandom), 1'b1);
            n += 3;
         end
      end

      // Let the driver and the block run dry, then allow for the longest sweep.
      @(negedge reset);
      while (cmd_queue.size() != 0 || start)
         @(posedge clock);
      while (victim_queue.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);

      $display("Run covered %0d transactions and %0d checked victims, %0d of them dirty.",
               accepted, victims_checked, dirty_victims);
      $display("Sweeps that cleared a full lap of referenced entries: %0d.", full_laps);
      if (failures == 0)
         $display("clock_replacement_map_cache_index verification clean");
      else
         $display("clock_replacement_map_cache_index verification failed");
      $finish;
   end

   // Watchdog: several times the slowest legal run, where every evict sweeps a full lap.
   initial begin
      #12_000_000;
      $display("clock_replacement_map_cache_index verification failed");
      $finish;
   end

endmodule

/* filelist.f */
design/crmc_pkg.sv
design/crmc_ctrl.sv
design/crmc_datapath.sv
design/clock_replacement_map_cache_index.sv
test/tb_top.sv
